[src/priority_task_scheduler_top_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the priority task scheduler
// Each macro expands to one labeled concurrent assertion on clk / rst_n.
// ----------------------------------------------------------------------------
`ifndef PRIORITY_TASK_SCHEDULER_TOP_ASSERT_SVH
`define PRIORITY_TASK_SCHEDULER_TOP_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define PTS_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define PTS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/pts_pkg.sv]
// ----------------------------------------------------------------------------
// pts_pkg
// Types and codes shared by the priority task scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

package pts_pkg;

    localparam int TAG_W  = 32;
    localparam int PRIO_W = 16;

    typedef enum logic [1:0] {
        ST_ACCEPTED   = 2'd0,
        ST_FULL       = 2'd1,
        ST_DISPATCHED = 2'd2,
        ST_EMPTY      = 2'd3
    } status_t;

    typedef enum logic {
        KIND_REGISTER = 1'b0,
        KIND_RUN      = 1'b1
    } kind_t;

    typedef enum logic [1:0] {
        S_IDLE   = 2'd0,
        S_SCAN   = 2'd1,
        S_FINISH = 2'd2,
        S_EMIT   = 2'd3
    } state_t;

    typedef struct packed {
        logic signed [PRIO_W-1:0] prio;
        logic [TAG_W-1:0]         tag;
    } slot_t;

endpackage

`default_nettype wire

[src/priority_task_scheduler_top.sv]
// ----------------------------------------------------------------------------
// priority_task_scheduler_top
// Task table in a synchronous memory; a run drains it by repeated max scans.
// ----------------------------------------------------------------------------
//  channel | handshake           | payload
//  --------+---------------------+---------------------------------------------
//  input   | in_valid / in_stall | kind, priority_req, task_tag
//  output  | out_valid/out_stall | status, out_tag, out_priority, last
//
//  Register item, or run on an empty table: one result.
//  Run with N stored tasks: N dispatches, each after a scan of the filled slots,
//  one slot read per cycle through the single read port of the slot memory.
//  Reset clears valid bits and counters at once; slot memory is not cleared.
//  A scan proceeds while a result waits; the dispatch waits for the output.
// ----------------------------------------------------------------------------
`default_nettype none

module priority_task_scheduler_top
    import pts_pkg::*;
#(
    parameter int CAPACITY = 16
)(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     in_valid,
    output logic                          in_stall,
    input  wire logic                     kind,
    input  wire logic signed [PRIO_W-1:0] priority_req,
    input  wire logic [TAG_W-1:0]         task_tag,
    output logic                          out_valid,
    input  wire logic                     out_stall,
    output logic [1:0]                    status,
    output logic [TAG_W-1:0]              out_tag,
    output logic signed [PRIO_W-1:0]      out_priority,
    output logic                          last
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    slot_t mem [CAPACITY];
    slot_t rd_data_reg;

    state_t                   state_reg, state_next;
    logic [CAPACITY-1:0]      valid_reg, valid_next;
    logic [CW-1:0]            fill_reg, fill_next;
    logic [CW-1:0]            left_reg, left_next;
    logic [AW-1:0]            scan_addr_reg, scan_addr_next;
    logic                     pend_reg, pend_next;
    logic [AW-1:0]            pend_idx_reg, pend_idx_next;
    logic                     best_found_reg, best_found_next;
    logic [AW-1:0]            best_idx_reg, best_idx_next;
    logic signed [PRIO_W-1:0] best_prio_reg, best_prio_next;
    logic [TAG_W-1:0]         best_tag_reg, best_tag_next;

    logic                     out_valid_reg, out_valid_next;
    status_t                  status_reg, status_next;
    logic [TAG_W-1:0]         tag_reg, tag_next;
    logic signed [PRIO_W-1:0] prio_reg, prio_next;
    logic                     last_reg, last_next;

    logic out_free;
    logic in_accept;
    logic mem_we;
    logic mem_re;
    logic take;

    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = !((state_reg == S_IDLE) && out_free);
    assign in_accept = in_valid && !in_stall;
    assign mem_we    = in_accept && (kind == KIND_REGISTER) && (fill_reg != CW'(CAPACITY));
    assign mem_re    = (state_reg == S_SCAN);
    assign take      = pend_reg && valid_reg[pend_idx_reg]
                       && (!best_found_reg || (rd_data_reg.prio > best_prio_reg));

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[fill_reg[AW-1:0]] <= '{prio: priority_req, tag: task_tag};
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[scan_addr_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            valid_reg      <= '0;
            fill_reg       <= '0;
            left_reg       <= '0;
            scan_addr_reg  <= '0;
            pend_reg       <= 1'b0;
            best_found_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            valid_reg      <= valid_next;
            fill_reg       <= fill_next;
            left_reg       <= left_next;
            scan_addr_reg  <= scan_addr_next;
            pend_reg       <= pend_next;
            best_found_reg <= best_found_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_idx_reg  <= pend_idx_next;
        best_idx_reg  <= best_idx_next;
        best_prio_reg <= best_prio_next;
        best_tag_reg  <= best_tag_next;
        status_reg    <= status_next;
        tag_reg       <= tag_next;
        prio_reg      <= prio_next;
        last_reg      <= last_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        valid_next      = valid_reg;
        fill_next       = fill_reg;
        left_next       = left_reg;
        scan_addr_next  = scan_addr_reg;
        pend_next       = 1'b0;
        pend_idx_next   = scan_addr_reg;
        best_found_next = best_found_reg;
        best_idx_next   = best_idx_reg;
        best_prio_next  = best_prio_reg;
        best_tag_next   = best_tag_reg;
        out_valid_next  = out_valid_reg && out_stall;
        status_next     = status_reg;
        tag_next        = tag_reg;
        prio_next       = prio_reg;
        last_next       = last_reg;

        // compare the entry read in the previous cycle
        if (take)
        begin
            best_found_next = 1'b1;
            best_idx_next   = pend_idx_reg;
            best_prio_next  = rd_data_reg.prio;
            best_tag_next   = rd_data_reg.tag;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    out_valid_next = 1'b1;
                    tag_next       = '0;
                    prio_next      = '0;
                    last_next      = 1'b1;
                    if (kind == KIND_REGISTER)
                    begin
                        if (fill_reg == CW'(CAPACITY))
                        begin
                            status_next = ST_FULL;
                        end
                        else
                        begin
                            status_next                  = ST_ACCEPTED;
                            valid_next[fill_reg[AW-1:0]] = 1'b1;
                            fill_next                    = fill_reg + CW'(1);
                        end
                    end
                    else if (fill_reg == '0)
                    begin
                        status_next = ST_EMPTY;
                    end
                    else
                    begin
                        out_valid_next  = out_valid_reg && out_stall;
                        left_next       = fill_reg;
                        scan_addr_next  = '0;
                        best_found_next = 1'b0;
                        state_next      = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                pend_next = 1'b1;
                if (CW'(scan_addr_reg) == fill_reg - CW'(1))
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    scan_addr_next = scan_addr_reg + AW'(1);
                end
            end
            S_FINISH:
            begin
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next          = 1'b1;
                    status_next             = ST_DISPATCHED;
                    tag_next                = best_tag_reg;
                    prio_next               = best_prio_reg;
                    valid_next[best_idx_reg] = 1'b0;
                    left_next               = left_reg - CW'(1);
                    best_found_next         = 1'b0;
                    scan_addr_next          = '0;
                    if (left_reg == CW'(1))
                    begin
                        last_next  = 1'b1;
                        fill_next  = '0;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        last_next  = 1'b0;
                        state_next = S_SCAN;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign out_tag      = tag_reg;
    assign out_priority = prio_reg;
    assign last         = last_reg;

`include "priority_task_scheduler_top_assert.svh"

    `PTS_ASSERT_IMPLY(a_fill_bound, 1'b1, fill_reg <= CW'(CAPACITY), "fill count exceeds capacity")
    `PTS_ASSERT_IMPLY(a_idle_count, state_reg == S_IDLE, $countones(valid_reg) == 32'(fill_reg), "valid bits disagree with fill count")
    `PTS_ASSERT_IMPLY(a_emit_best, state_reg == S_EMIT, best_found_reg && valid_reg[best_idx_reg], "dispatch without a valid best slot")
    `PTS_ASSERT_NEXT(a_drain_clears, state_reg == S_EMIT && out_free && left_reg == CW'(1), valid_reg == '0 && fill_reg == '0, "table not empty after drain")

endmodule

`default_nettype wire
